[hdl/rotated_prism_perspective_projector_macros.svh]
// Assertion macros shared by the prism projector RTL.
`ifndef ROTATED_PRISM_PERSPECTIVE_PROJECTOR_MACROS_SVH
`define ROTATED_PRISM_PERSPECTIVE_PROJECTOR_MACROS_SVH

// Property checked at every clock edge outside reset.
`define RPP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define RPP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[hdl/rpp_pkg.sv]
// Shared types, constants and tables of the prism projector.
package rpp_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int ANGLE_BITS = 16;

  localparam int Q30 = 30;
  localparam logic [Q30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [Q30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam int POLY_STEPS  = 7;
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_W     = 38;
  localparam logic [RECIP_W-1:0] RECIP [POLY_STEPS] = '{
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6)
  };

  localparam int TRIG_W   = FRAC_BITS + 2;
  localparam int COORD_W  = FRAC_BITS + 12;
  localparam int NUM_W    = COORD_W + 12;
  localparam int DEN_W    = COORD_W - 1;
  localparam int QUO_BITS = 18;
  localparam int DSH_W    = DEN_W + QUO_BITS - 1;

  localparam int NPOINTS    = 24;
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = 5;
  localparam int CNT_W      = FIFO_AW + 1;

  // Corner times two plus level (1 is the top level), in output order.
  localparam logic [2:0] FACE_TAB [NPOINTS] = '{
    3'd1, 3'd3, 3'd5, 3'd7,
    3'd0, 3'd2, 3'd4, 3'd6,
    3'd3, 3'd2, 3'd4, 3'd5,
    3'd7, 3'd5, 3'd4, 3'd6,
    3'd7, 3'd6, 3'd0, 3'd1,
    3'd2, 3'd3, 3'd1, 3'd0
  };

  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef enum logic [2:0] {
    REG_SCALE        = 3'd0,
    REG_OFFSET_X     = 3'd1,
    REG_OFFSET_Y     = 3'd2,
    REG_OFFSET_Z     = 3'd3,
    REG_PRISM_HEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] quad;
  } sctl_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] face;
    logic [1:0] point;
    logic       last;
    logic       neg_x;
    logic       neg_y;
    logic       dz;
  } pmeta_t;

  typedef struct packed {
    logic [2:0]         face;
    logic [1:0]         point;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               dz;
    logic               last;
  } point_t;

endpackage

[hdl/rpp_poly_cell.sv]
// One nested-polynomial step of the quarter sine: h = 1 - t2*h/d.
module rpp_poly_cell
  import rpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [RECIP_W-1:0] recip,
  input  sctl_t              ctl_i,
  input  logic [Q30:0]       t_i,
  input  logic [Q30+1:0]     t2_i,
  input  logic [Q30:0]       h_i,
  output sctl_t              ctl_o,
  output logic [Q30:0]       t_o,
  output logic [Q30+1:0]     t2_o,
  output logic [Q30:0]       h_o
);

  localparam int PA_W = 2 * Q30 + 3;
  localparam int PB_W = Q30 + 2 + RECIP_W;

  logic [PA_W-1:0]  prod_a;
  logic [PB_W-1:0]  prod_b;
  sctl_t            ctl_a_r;
  logic [Q30:0]     t_a_r;
  logic [Q30+1:0]   t2_a_r;
  logic [Q30+1:0]   x_a_r;
  sctl_t            ctl_b_r;
  logic [Q30:0]     t_b_r;
  logic [Q30+1:0]   t2_b_r;
  logic [Q30:0]     h_b_r;
  logic [Q30-1:0]   quo;

  assign prod_a = PA_W'(t2_i) * PA_W'(h_i);
  assign prod_b = PB_W'(x_a_r) * PB_W'(recip);
  assign quo    = prod_b[RECIP_SHIFT+Q30-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r.valid <= 1'b0;
      ctl_b_r.valid <= 1'b0;
    end else begin
      ctl_a_r.valid <= ctl_i.valid;
      ctl_b_r.valid <= ctl_a_r.valid;
    end
    ctl_a_r.quad <= ctl_i.quad;
    t_a_r        <= t_i;
    t2_a_r       <= t2_i;
    x_a_r        <= prod_a[2*Q30+1:Q30];
    ctl_b_r.quad <= ctl_a_r.quad;
    t_b_r        <= t_a_r;
    t2_b_r       <= t2_a_r;
    h_b_r        <= Q30_ONE - (Q30+1)'(quo);
  end

  assign ctl_o = ctl_b_r;
  assign t_o   = t_b_r;
  assign t2_o  = t2_b_r;
  assign h_o   = h_b_r;

endmodule

[hdl/rpp_sine.sv]
// Quarter-wave sine lane: argument scaling, a chain of polynomial cells, rounding.
module rpp_sine
  import rpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sctl_t              ctl_i,
  input  logic [Q30:0]       v_i,
  output sctl_t              ctl_o,
  output logic [FRAC_BITS:0] r_o
);

  localparam int P_W = 2 * Q30 + 2;

  logic [P_W-1:0]  p0;
  logic [P_W-1:0]  p1;
  logic [P_W-1:0]  p2;
  sctl_t           ctl0_r;
  logic [Q30:0]    t0_r;
  sctl_t           ctl_c [POLY_STEPS+1];
  logic [Q30:0]    t_c   [POLY_STEPS+1];
  logic [Q30+1:0]  t2_c  [POLY_STEPS+1];
  logic [Q30:0]    h_c   [POLY_STEPS+1];
  sctl_t           ctl1_r;
  logic [Q30:0]    t1_r;
  logic [Q30+1:0]  t2_1_r;
  sctl_t           ctlp_r;
  logic [Q30:0]    s_r;
  sctl_t           ctlr_r;
  logic [FRAC_BITS:0] r_r;
  logic [Q30+1:0]  rnd;
  logic [Q30+1:0]  shf;
  logic [FRAC_BITS:0] r_nxt;

  assign p0 = P_W'(v_i) * P_W'(HALF_PI_Q30);
  assign p1 = P_W'(t0_r) * P_W'(t0_r);
  assign p2 = P_W'(t_c[POLY_STEPS]) * P_W'(h_c[POLY_STEPS]);

  assign ctl_c[0] = ctl1_r;
  assign t_c[0]   = t1_r;
  assign t2_c[0]  = t2_1_r;
  assign h_c[0]   = Q30_ONE;

  for (genvar i = 0; i < POLY_STEPS; i++) begin : g_cell
    rpp_poly_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .recip (RECIP[i]),
      .ctl_i (ctl_c[i]),
      .t_i   (t_c[i]),
      .t2_i  (t2_c[i]),
      .h_i   (h_c[i]),
      .ctl_o (ctl_c[i+1]),
      .t_o   (t_c[i+1]),
      .t2_o  (t2_c[i+1]),
      .h_o   (h_c[i+1])
    );
  end

  always_comb begin
    rnd = (Q30+2)'(s_r) + ((Q30+2)'(1) << (Q30 - 1 - FRAC_BITS));
    shf = rnd >> (Q30 - FRAC_BITS);
    if (shf > ((Q30+2)'(1) << FRAC_BITS)) begin
      r_nxt = (FRAC_BITS+1)'(1) << FRAC_BITS;
    end else begin
      r_nxt = shf[FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.valid <= 1'b0;
      ctl1_r.valid <= 1'b0;
      ctlp_r.valid <= 1'b0;
      ctlr_r.valid <= 1'b0;
    end else begin
      ctl0_r.valid <= ctl_i.valid;
      ctl1_r.valid <= ctl0_r.valid;
      ctlp_r.valid <= ctl_c[POLY_STEPS].valid;
      ctlr_r.valid <= ctlp_r.valid;
    end
    ctl0_r.quad <= ctl_i.quad;
    t0_r        <= p0[2*Q30:Q30];
    ctl1_r.quad <= ctl0_r.quad;
    t1_r        <= t0_r;
    t2_1_r      <= p1[2*Q30+1:Q30];
    ctlp_r.quad <= ctl_c[POLY_STEPS].quad;
    s_r         <= p2[2*Q30:Q30];
    ctlr_r.quad <= ctlp_r.quad;
    r_r         <= r_nxt;
  end

  assign ctl_o = ctlr_r;
  assign r_o   = r_r;

endmodule

[hdl/rpp_div_cell.sv]
// One restoring division step for the x and y numerators over a shared divisor.
module rpp_div_cell
  import rpp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  pmeta_t              meta_i,
  input  logic [NUM_W-1:0]    rem_x_i,
  input  logic [NUM_W-1:0]    rem_y_i,
  input  logic [QUO_BITS-1:0] qx_i,
  input  logic [QUO_BITS-1:0] qy_i,
  input  logic [DSH_W-1:0]    dsh_i,
  output pmeta_t              meta_o,
  output logic [NUM_W-1:0]    rem_x_o,
  output logic [NUM_W-1:0]    rem_y_o,
  output logic [QUO_BITS-1:0] qx_o,
  output logic [QUO_BITS-1:0] qy_o,
  output logic [DSH_W-1:0]    dsh_o
);

  pmeta_t              meta_r;
  logic [NUM_W-1:0]    rem_x_r;
  logic [NUM_W-1:0]    rem_y_r;
  logic [QUO_BITS-1:0] qx_r;
  logic [QUO_BITS-1:0] qy_r;
  logic [DSH_W-1:0]    dsh_r;
  logic                ge_x;
  logic                ge_y;

  assign ge_x = DSH_W'(rem_x_i) >= dsh_i;
  assign ge_y = DSH_W'(rem_y_i) >= dsh_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r <= '0;
    end else begin
      meta_r <= meta_i;
    end
    rem_x_r <= ge_x ? rem_x_i - NUM_W'(dsh_i) : rem_x_i;
    rem_y_r <= ge_y ? rem_y_i - NUM_W'(dsh_i) : rem_y_i;
    qx_r    <= {qx_i[QUO_BITS-2:0], ge_x};
    qy_r    <= {qy_i[QUO_BITS-2:0], ge_y};
    dsh_r   <= dsh_i >> 1;
  end

  assign meta_o  = meta_r;
  assign rem_x_o = rem_x_r;
  assign rem_y_o = rem_y_r;
  assign qx_o    = qx_r;
  assign qy_o    = qy_r;
  assign dsh_o   = dsh_r;

endmodule

[hdl/rotated_prism_perspective_projector.sv]
// Top level: sine/cosine lanes, point sequencer, divider cell chain and result queue.
// An accepted angle yields its points in order, one point per cycle unless queue credit or out_ready stalls.
// Sustained throughput is set by the point sequencer, which issues 24 points per angle.
// A new angle is taken while the previous one is still emitting points.
// Reset is synchronous and active low; it clears control state and restores the
// register defaults. There is no clearing pass.
`include "rotated_prism_perspective_projector_macros.svh"

module rotated_prism_perspective_projector
  import rpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_face_index,
  output logic [1:0]         out_point_index,
  output logic signed [15:0] out_screen_x,
  output logic signed [15:0] out_screen_y,
  output logic               out_div_zero,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  logic [11:0]        scale_r;
  logic signed [10:0] offset_x_r;
  logic signed [10:0] offset_y_r;
  logic signed [10:0] offset_z_r;
  logic [9:0]         height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= 12'd256;
      offset_x_r <= '0;
      offset_y_r <= '0;
      offset_z_r <= -11'sd4;
      height_r   <= 10'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:        scale_r    <= cfg_data;
        REG_OFFSET_X:     offset_x_r <= cfg_data[10:0];
        REG_OFFSET_Y:     offset_y_r <= cfg_data[10:0];
        REG_OFFSET_Z:     offset_z_r <= cfg_data[10:0];
        REG_PRISM_HEIGHT: height_r   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Angle intake and the two sine lanes.
  logic               in_fire;
  logic [31:0]        phase;
  sctl_t              sin_ctl_i;
  sctl_t              sin_ctl_a;
  sctl_t              sin_ctl_b;
  logic [FRAC_BITS:0] ra;
  logic [FRAC_BITS:0] rb;
  logic               pp_busy_r;
  logic               hold_valid_r;

  assign in_ready  = !pp_busy_r && !hold_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign phase     = {in_angle[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
  assign sin_ctl_i = '{valid: in_fire, quad: phase[31:30]};

  rpp_sine u_sine_a (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (sin_ctl_i),
    .v_i   ({1'b0, phase[29:0]}),
    .ctl_o (sin_ctl_a),
    .r_o   (ra)
  );

  rpp_sine u_sine_b (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (sin_ctl_i),
    .v_i   (Q30_ONE - {1'b0, phase[29:0]}),
    .ctl_o (sin_ctl_b),
    .r_o   (rb)
  );

  trig_t av;
  trig_t bv;
  trig_t s_new;
  trig_t c_new;

  assign av = trig_t'(ra);
  assign bv = trig_t'(rb);

  always_comb begin
    case (sin_ctl_a.quad)
      2'd0:    begin s_new = av;  c_new = bv;  end
      2'd1:    begin s_new = bv;  c_new = -av; end
      2'd2:    begin s_new = -av; c_new = -bv; end
      default: begin s_new = -bv; c_new = av;  end
    endcase
  end

  // Item slots and point sequencer.
  logic       sin_valid;
  logic       cur_valid_r;
  trig_t      cur_s_r;
  trig_t      cur_c_r;
  trig_t      hold_s_r;
  trig_t      hold_c_r;
  logic [4:0] pt_r;
  logic [2:0] face_r;
  logic [1:0] pidx_r;
  logic       credit_ok;
  logic       issue;
  logic       cur_done;
  logic       cur_free;
  logic [CNT_W-1:0] inflight_r;
  logic [CNT_W-1:0] fifo_cnt_r;
  logic [CNT_W:0]   credit_sum;

  assign sin_valid  = sin_ctl_a.valid;
  assign credit_sum = {1'b0, inflight_r} + {1'b0, fifo_cnt_r};
  assign credit_ok  = credit_sum < (CNT_W+1)'(FIFO_DEPTH);
  assign issue      = cur_valid_r && credit_ok;
  assign cur_done   = issue && (pt_r == 5'(NPOINTS - 1));
  assign cur_free   = !cur_valid_r || cur_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_busy_r    <= 1'b0;
      hold_valid_r <= 1'b0;
      cur_valid_r  <= 1'b0;
      pt_r         <= '0;
      face_r       <= '0;
      pidx_r       <= '0;
    end else begin
      if (in_fire) begin
        pp_busy_r <= 1'b1;
      end else if (sin_valid) begin
        pp_busy_r <= 1'b0;
      end
      if (cur_free) begin
        if (hold_valid_r) begin
          cur_valid_r  <= 1'b1;
          hold_valid_r <= sin_valid;
        end else begin
          cur_valid_r  <= sin_valid;
        end
      end else if (sin_valid) begin
        hold_valid_r <= 1'b1;
      end
      if (issue) begin
        if (cur_done) begin
          pt_r   <= '0;
          face_r <= '0;
          pidx_r <= '0;
        end else begin
          pt_r   <= pt_r + 5'd1;
          pidx_r <= pidx_r + 2'd1;
          if (pidx_r == 2'd3) begin
            face_r <= face_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cur_free) begin
      if (hold_valid_r) begin
        cur_s_r <= hold_s_r;
        cur_c_r <= hold_c_r;
        hold_s_r <= s_new;
        hold_c_r <= c_new;
      end else begin
        cur_s_r <= s_new;
        cur_c_r <= c_new;
      end
    end else if (sin_valid) begin
      hold_s_r <= s_new;
      hold_c_r <= c_new;
    end
  end

  // Corner selection.
  logic [2:0] fe;
  trig_t      cx_sel;
  trig_t      cz_sel;
  pmeta_t     e1_meta_r;
  trig_t      e1_cx_r;
  trig_t      e1_cz_r;
  logic       e1_lvl_r;

  assign fe = FACE_TAB[pt_r];

  always_comb begin
    case (fe[2:1])
      2'd0:    begin cx_sel = -cur_s_r; cz_sel = cur_c_r;  end
      2'd1:    begin cx_sel = -cur_c_r; cz_sel = -cur_s_r; end
      2'd2:    begin cx_sel = cur_s_r;  cz_sel = -cur_c_r; end
      default: begin cx_sel = cur_c_r;  cz_sel = cur_s_r;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_meta_r <= '0;
    end else begin
      e1_meta_r <= '{valid: issue, face: face_r, point: pidx_r, last: cur_done,
                     neg_x: 1'b0, neg_y: 1'b0, dz: 1'b0};
    end
    e1_cx_r  <= cx_sel;
    e1_cz_r  <= cz_sel;
    e1_lvl_r <= fe[0];
  end

  // Numerators and denominator.
  logic signed [COORD_W-1:0] offx_w;
  logic signed [COORD_W-1:0] offy_w;
  logic signed [COORD_W-1:0] offz_w;
  logic signed [COORD_W-1:0] hgt_w;
  logic signed [COORD_W-1:0] xs;
  logic signed [COORD_W-1:0] ys;
  logic signed [COORD_W-1:0] den;
  logic signed [NUM_W-1:0]   sc_w;
  pmeta_t                    e2_meta_r;
  logic signed [NUM_W-1:0]   e2_nx_r;
  logic signed [NUM_W-1:0]   e2_ny_r;
  logic signed [COORD_W-1:0] e2_den_r;

  assign offx_w = COORD_W'(offset_x_r) <<< FRAC_BITS;
  assign offy_w = COORD_W'(offset_y_r) <<< FRAC_BITS;
  assign offz_w = COORD_W'(offset_z_r) <<< FRAC_BITS;
  assign hgt_w  = signed'(COORD_W'(height_r)) <<< FRAC_BITS;
  assign xs     = COORD_W'(e1_cx_r) + offx_w;
  assign ys     = (e1_lvl_r ? hgt_w : COORD_W'(0)) + offy_w;
  assign den    = COORD_W'(e1_cz_r) - offz_w;
  assign sc_w   = NUM_W'(signed'({1'b0, scale_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_meta_r <= '0;
    end else begin
      e2_meta_r <= e1_meta_r;
    end
    e2_nx_r  <= NUM_W'(xs) * sc_w;
    e2_ny_r  <= NUM_W'(ys) * sc_w;
    e2_den_r <= den;
  end

  // Magnitudes and signs, then the divider cell chain.
  pmeta_t                    e3_meta;
  logic [NUM_W-1:0]          nx_mag;
  logic [NUM_W-1:0]          ny_mag;
  logic [COORD_W-1:0]        den_abs;
  pmeta_t                    d_meta [QUO_BITS+1];
  logic [NUM_W-1:0]          d_rem_x [QUO_BITS+1];
  logic [NUM_W-1:0]          d_rem_y [QUO_BITS+1];
  logic [QUO_BITS-1:0]       d_qx [QUO_BITS+1];
  logic [QUO_BITS-1:0]       d_qy [QUO_BITS+1];
  logic [DSH_W-1:0]          d_dsh [QUO_BITS+1];
  pmeta_t                    e3_meta_r;
  logic [NUM_W-1:0]          e3_nx_r;
  logic [NUM_W-1:0]          e3_ny_r;
  logic [DSH_W-1:0]          e3_dsh_r;

  assign nx_mag  = e2_nx_r[NUM_W-1] ? NUM_W'(-e2_nx_r) : NUM_W'(e2_nx_r);
  assign ny_mag  = e2_ny_r[NUM_W-1] ? NUM_W'(-e2_ny_r) : NUM_W'(e2_ny_r);
  assign den_abs = e2_den_r[COORD_W-1] ? COORD_W'(-e2_den_r) : COORD_W'(e2_den_r);

  always_comb begin
    e3_meta       = e2_meta_r;
    e3_meta.neg_x = e2_nx_r[NUM_W-1] ^ e2_den_r[COORD_W-1];
    e3_meta.neg_y = e2_ny_r[NUM_W-1] ^ e2_den_r[COORD_W-1];
    e3_meta.dz    = (e2_den_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3_meta_r <= '0;
    end else begin
      e3_meta_r <= e3_meta;
    end
    e3_nx_r  <= nx_mag;
    e3_ny_r  <= ny_mag;
    e3_dsh_r <= {den_abs[DEN_W-1:0], {(QUO_BITS-1){1'b0}}};
  end

  assign d_meta[0]  = e3_meta_r;
  assign d_rem_x[0] = e3_nx_r;
  assign d_rem_y[0] = e3_ny_r;
  assign d_qx[0]    = '0;
  assign d_qy[0]    = '0;
  assign d_dsh[0]   = e3_dsh_r;

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
    rpp_div_cell u_div_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .meta_i  (d_meta[i]),
      .rem_x_i (d_rem_x[i]),
      .rem_y_i (d_rem_y[i]),
      .qx_i    (d_qx[i]),
      .qy_i    (d_qy[i]),
      .dsh_i   (d_dsh[i]),
      .meta_o  (d_meta[i+1]),
      .rem_x_o (d_rem_x[i+1]),
      .rem_y_o (d_rem_y[i+1]),
      .qx_o    (d_qx[i+1]),
      .qy_o    (d_qy[i+1]),
      .dsh_o   (d_dsh[i+1])
    );
  end

  // Sign, saturation and zero-divisor handling.
  pmeta_t              post_meta;
  logic [QUO_BITS-1:0] qx;
  logic [QUO_BITS-1:0] qy;
  logic signed [15:0]  sx;
  logic signed [15:0]  sy;
  point_t              post_pt;

  assign post_meta = d_meta[QUO_BITS];
  assign qx        = d_qx[QUO_BITS];
  assign qy        = d_qy[QUO_BITS];

  always_comb begin
    if (post_meta.dz) begin
      sx = '0;
    end else if (!post_meta.neg_x) begin
      sx = (qx > QUO_BITS'(32767)) ? 16'sh7fff : qx[15:0];
    end else begin
      sx = (qx > QUO_BITS'(32768)) ? 16'sh8000 : 16'(-qx);
    end
    if (post_meta.dz) begin
      sy = '0;
    end else if (!post_meta.neg_y) begin
      sy = (qy > QUO_BITS'(32767)) ? 16'sh7fff : qy[15:0];
    end else begin
      sy = (qy > QUO_BITS'(32768)) ? 16'sh8000 : 16'(-qy);
    end
    post_pt = '{face: post_meta.face, point: post_meta.point, sx: sx, sy: sy,
                dz: post_meta.dz, last: post_meta.last};
  end

  // Result queue and output register.
  point_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic                 rd_fire;
  logic                 out_valid_r;
  point_t               out_pt_r;

  assign rd_fire = (fifo_cnt_r != '0) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (post_meta.valid) begin
      fifo_mem[wr_ptr_r] <= post_pt;
    end
    if (rd_fire) begin
      out_pt_r <= fifo_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fifo_cnt_r  <= '0;
      inflight_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (post_meta.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + CNT_W'(post_meta.valid) - CNT_W'(rd_fire);
      inflight_r <= inflight_r + CNT_W'(issue) - CNT_W'(post_meta.valid);
      if (rd_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_face_index  = out_pt_r.face;
  assign out_point_index = out_pt_r.point;
  assign out_screen_x    = out_pt_r.sx;
  assign out_screen_y    = out_pt_r.sy;
  assign out_div_zero    = out_pt_r.dz;
  assign out_last        = out_pt_r.last;

  `RPP_ASSERT(a_no_overbook, credit_sum <= (CNT_W+1)'(FIFO_DEPTH), "queue overbooked")
  `RPP_ASSERT(a_lanes_aligned, sin_ctl_a.valid == sin_ctl_b.valid, "sine lanes out of step")
  `RPP_ASSERT(a_sine_expected, !sin_valid || (pp_busy_r && !hold_valid_r), "unexpected sine")
  `RPP_ASSERT(a_point_tracked, !post_meta.valid || (inflight_r != '0), "untracked point")
  `RPP_ASSERT_NEXT(a_accept_blocks, in_fire, !in_ready, "intake open while busy")

endmodule

[sim/rotated_prism_perspective_projector_tb.sv]
// Testbench for the prism projector: predicted points checked against every result transfer.
`timescale 1ns / 100ps

module rotated_prism_perspective_projector_tb;
  import rpp_pkg::*;

  localparam logic [2:0] REG_NONE = 3'd6;
  localparam int SETTLE = 60;

  class point_scoreboard;
    point_t expected_points[$];
    logic [11:0] scale;
    logic signed [10:0] offset_x, offset_y, offset_z;
    logic [9:0] prism_height;
    int errors, angles, points, zero_div;

    function new();
      scale = 12'd256;
      offset_x = '0;
      offset_y = '0;
      offset_z = -11'sd4;
      prism_height = 10'd1;
    endfunction

    function void set_reg(logic [2:0] idx, logic [11:0] data);
      case (idx)
        REG_SCALE:        scale = data;
        REG_OFFSET_X:     offset_x = data[10:0];
        REG_OFFSET_Y:     offset_y = data[10:0];
        REG_OFFSET_Z:     offset_z = data[10:0];
        REG_PRISM_HEIGHT: prism_height = data[9:0];
        default: ;
      endcase
    endfunction

    function longint quarter_sine(longint unsigned v);
      longint unsigned t, t2, h, s, r;
      t = (v * 64'd1686629713) >> 30;
      t2 = (t * t) >> 30;
      h = 64'd1 << 30;
      for (int k = 7; k >= 1; k--)
        h = (64'd1 << 30) - ((t2 * h) >> 30) / longint'((2 * k) * (2 * k + 1));
      s = (t * h) >> 30;
      r = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (r > (64'd1 << FRAC_BITS)) r = 64'd1 << FRAC_BITS;
      return longint'(r);
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void note_angle(logic [15:0] angle);
      logic [31:0] phase;
      longint unsigned u;
      longint a, b, s, c, y, nx, ny, den, one;
      longint cx[4], cz[4];
      int k;
      point_t p;
      one = longint'(1) << FRAC_BITS;
      phase = {angle, 16'd0};
      u = phase[29:0];
      a = quarter_sine(u);
      b = quarter_sine((64'd1 << 30) - u);
      case (phase[31:30])
        2'd0: begin s = a; c = b; end
        2'd1: begin s = b; c = -a; end
        2'd2: begin s = -a; c = -b; end
        default: begin s = -b; c = a; end
      endcase
      cx[0] = -s; cz[0] = c;
      cx[1] = -c; cz[1] = -s;
      cx[2] = s;  cz[2] = -c;
      cx[3] = c;  cz[3] = s;
      for (int i = 0; i < NPOINTS; i++) begin
        k = FACE_TAB[i] >> 1;
        y = FACE_TAB[i][0] ? longint'(prism_height) * one : 0;
        nx = (cx[k] + longint'(offset_x) * one) * longint'(scale);
        ny = (y + longint'(offset_y) * one) * longint'(scale);
        den = cz[k] - longint'(offset_z) * one;
        p.face = 3'(i / 4);
        p.point = 2'(i % 4);
        p.last = (i == NPOINTS - 1);
        if (den == 0) begin
          p.dz = 1'b1; p.sx = '0; p.sy = '0;
          zero_div++;
        end else begin
          p.dz = 1'b0;
          p.sx = 16'(clip16(nx / den));
          p.sy = 16'(clip16(ny / den));
        end
        expected_points.push_back(p);
      end
      angles++;
    endfunction

    function void check_point(point_t got);
      point_t exp_p;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point transfer face %0d point %0d",
                 $time, got.face, got.point);
        errors++;
        return;
      end
      exp_p = expected_points.pop_front();
      points++;
      if (got !== exp_p) begin
        $display("%0t: mismatch expected face %0d point %0d x %0d y %0d dz %0b last %0b",
                 $time, exp_p.face, exp_p.point, exp_p.sx, exp_p.sy, exp_p.dz, exp_p.last);
        $display("%0t:          actual   face %0d point %0d x %0d y %0d dz %0b last %0b",
                 $time, got.face, got.point, got.sx, got.sy, got.dz, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_face_index;
  logic [1:0] out_point_index;
  logic signed [15:0] out_screen_x, out_screen_y;
  logic out_div_zero, out_last;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_SCALE;
  logic [11:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  point_scoreboard sb = new();

  rotated_prism_perspective_projector u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_angle(in_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_face_index(out_face_index), .out_point_index(out_point_index),
    .out_screen_x(out_screen_x), .out_screen_y(out_screen_y),
    .out_div_zero(out_div_zero), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_point('{face: out_face_index, point: out_point_index, sx: out_screen_x,
                       sy: out_screen_y, dz: out_div_zero, last: out_last});
  end

  task automatic send_angle(logic [15:0] angle);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_angle = angle;
    do @(posedge clk); while (!in_ready);
    sb.note_angle(angle);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_points.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [11:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic random_angle();
    case ($urandom_range(3))
      0: send_angle(16'($urandom_range(3)) << 14);
      1: send_angle((16'($urandom_range(3)) << 14) + 16'($urandom_range(8)) - 16'd4);
      default: send_angle(16'($urandom));
    endcase
  endtask

  initial begin
    #(12 * 400000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: reset settings, quadrant edges, zero divisors, saturation.
    send_angle(16'd0);
    send_angle(16'd16384);
    send_angle(16'd32768);
    send_angle(16'd49152);
    send_angle(16'hFFFF);
    send_angle(16'd1);
    drain();
    write_reg(REG_OFFSET_Z, 12'd0);
    send_angle(16'd0);
    send_angle(16'd16384);
    send_angle(16'd32768);
    send_angle(16'd49152);
    drain();
    write_reg(REG_SCALE, 12'd4095);
    write_reg(REG_OFFSET_X, 12'h3FF);
    write_reg(REG_OFFSET_Y, 12'h400);
    write_reg(REG_PRISM_HEIGHT, 12'h3FF);
    send_angle(16'd1);
    send_angle(16'd16383);
    send_angle(16'd32769);
    drain();
    write_reg(REG_SCALE, 12'd0);
    write_reg(REG_NONE, 12'hABC);
    write_reg(REG_OFFSET_X, 12'hFFF);
    write_reg(REG_OFFSET_Z, 12'hC01);
    send_angle(16'h5555);
    drain();
    write_reg(REG_SCALE, 12'd1);
    send_angle(16'hAAAA);
    send_angle(16'd49153);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if (ph == 1) begin
        write_reg(REG_SCALE, 12'd4095);
        write_reg(REG_OFFSET_X, 12'h3FF);
        write_reg(REG_OFFSET_Y, 12'h3FF);
        write_reg(REG_OFFSET_Z, 12'h3FF);
        write_reg(REG_PRISM_HEIGHT, 12'h3FF);
      end else if (ph == 2) begin
        write_reg(REG_SCALE, 12'd1);
        write_reg(REG_OFFSET_X, 12'h400);
        write_reg(REG_OFFSET_Y, 12'h400);
        write_reg(REG_OFFSET_Z, 12'h400);
        write_reg(REG_PRISM_HEIGHT, 12'h000);
      end else begin
        write_reg(REG_SCALE, 12'($urandom_range(4095, 1)));
        write_reg(REG_OFFSET_X, 12'($urandom));
        write_reg(REG_OFFSET_Y, 12'($urandom));
        write_reg(REG_OFFSET_Z, 12'($urandom_range(2)) - 12'd1);
        write_reg(REG_PRISM_HEIGHT, 12'($urandom));
      end
      for (int i = 0; i < 25; i++) random_angle();
      drain();
    end

    if (sb.expected_points.size() != 0) sb.errors++;
    $display("Checked %0d points from %0d angles, %0d with a zero divisor.",
             sb.points, sb.angles, sb.zero_div);
    $display("Settings covered reset values, both register extremes and random values.");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/rpp_pkg.sv
hdl/rpp_poly_cell.sv
hdl/rpp_sine.sv
hdl/rpp_div_cell.sv
hdl/rotated_prism_perspective_projector.sv
sim/rotated_prism_perspective_projector_tb.sv
